// File: rtl/core/pin_interrupt_event_queue_macros.svh
// ----------------------------------------------------------------------------
// Pin interrupt event queue: assertion macros
// Concurrent checks on the rising edge of i_clk, masked while i_rst_n is low.
// Synthesis builds define SYNTH and get empty bodies.
// ----------------------------------------------------------------------------
`ifndef PIN_INTERRUPT_EVENT_QUEUE_MACROS_SVH
`define PIN_INTERRUPT_EVENT_QUEUE_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define PIEQ_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PIEQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`else

`define PIEQ_ASSERT_NOW(name, ante, cons, msg)
`define PIEQ_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// File: rtl/core/pieq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pin interrupt event queue package
// Field widths, mode codes and the sequencer state type.
// ----------------------------------------------------------------------------
package pieq_pkg;

    // Payload field widths
    localparam int STATUS_W = 32;
    localparam int PIN_W    = 5;
    localparam int DROP_W   = 6;
    localparam int ENTRY_W  = PIN_W + 1;

    // Item mode codes
    localparam logic MODE_CAPTURE = 1'b0;
    localparam logic MODE_POP     = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_READ = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

endpackage

// File: rtl/core/pieq_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pin interrupt event queue: input channel
// Valid/ready channel carrying one capture or pop request.
// ----------------------------------------------------------------------------
interface pieq_in_if;

    logic                            valid;
    logic                            ready;
    logic                            mode;
    logic [pieq_pkg::STATUS_W-1:0]   int_status;
    logic [pieq_pkg::STATUS_W-1:0]   pin_levels;

    modport source (output valid, output mode, output int_status, output pin_levels,
                    input ready);
    modport sink   (input valid, input mode, input int_status, input pin_levels,
                    output ready);

endinterface

// File: rtl/core/pieq_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pin interrupt event queue: result channel
// Valid/ready channel carrying one popped event or a capture drop count.
// ----------------------------------------------------------------------------
interface pieq_out_if;

    logic                            valid;
    logic                            ready;
    logic                            event_valid;
    logic [pieq_pkg::PIN_W-1:0]      event_pin;
    logic                            event_level;
    logic [pieq_pkg::DROP_W-1:0]     events_dropped;

    modport source (output valid, output event_valid, output event_pin,
                    output event_level, output events_dropped, input ready);
    modport sink   (input valid, input event_valid, input event_pin,
                    input event_level, input events_dropped, output ready);

endinterface

// File: rtl/core/pin_interrupt_event_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pin interrupt event queue
// Captures one event per pending interrupt pin into a circular queue, counting
// the events it drops when full, and pops the oldest event on request.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  i_in      in   valid / ready      mode, int_status, pin_levels
//  o_out     out  valid / ready      event_valid, event_pin, event_level,
//                                    events_dropped
//
//  A capture scans min(PIN_COUNT, 32) pins: the scan steps one pin per
//  cycle through the shared pointer advance/compare and the single RAM write
//  port. A pop reads the RAM (registered read data); an empty pop skips the read.
//  One item is in work at a time; i_in.ready is high only when idle.
//  The result waits in an output register; a stalled o_out holds the block.
//  Synchronous active-low reset empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
`include "pin_interrupt_event_queue_macros.svh"

module pin_interrupt_event_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int PIN_COUNT   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pieq_in_if.sink     i_in,
    pieq_out_if.source  o_out
);

    import pieq_pkg::*;

    localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SCAN_PINS = (PIN_COUNT < STATUS_W) ? PIN_COUNT : STATUS_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [PIN_W-1:0] PIN_LAST = PIN_W'(SCAN_PINS - 1);

    // Sequencer and queue state
    t_state               r_state,  n_state;
    logic [PTR_W-1:0]     r_wp,     n_wp;
    logic [PTR_W-1:0]     r_rp,     n_rp;
    logic [STATUS_W-1:0]  r_status, n_status;
    logic [STATUS_W-1:0]  r_levels, n_levels;
    logic [PIN_W-1:0]     r_pin,    n_pin;
    logic [DROP_W-1:0]    r_drop,   n_drop;
    logic                 r_hit,    n_hit;

    // Output register
    logic                 r_out_valid;
    logic                 r_ev_valid;
    logic [PIN_W-1:0]     r_ev_pin;
    logic                 r_ev_level;
    logic [DROP_W-1:0]    r_ev_drop;

    logic [PTR_W-1:0]     wp_next;
    logic [PTR_W-1:0]     rp_next;
    logic                 out_free;
    logic                 ram_we;
    logic                 ram_re;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;

    // Event store
    pieq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rp),
        .o_rdata (ram_rdata)
    );

    // Advance pointers with wrap at the queue depth
    assign wp_next = (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
    assign rp_next = (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;

    assign ram_wdata = {r_levels[0], r_pin};
    assign out_free  = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    // Sequence capture scans and pops
    always_comb begin
        n_state  = r_state;
        n_wp     = r_wp;
        n_rp     = r_rp;
        n_status = r_status;
        n_levels = r_levels;
        n_pin    = r_pin;
        n_drop   = r_drop;
        n_hit    = r_hit;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_drop = '0;
                    if (i_in.mode == MODE_CAPTURE) begin
                        n_status = i_in.int_status;
                        n_levels = i_in.pin_levels;
                        n_pin    = '0;
                        n_hit    = 1'b0;
                        n_state  = ST_SCAN;
                    end else begin
                        n_hit   = (r_wp != r_rp);
                        n_state = (r_wp != r_rp) ? ST_READ : ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                // push one pin per cycle, drop when one slot is left
                if (r_status[0]) begin
                    if (wp_next == r_rp) begin
                        n_drop = r_drop + 1'b1;
                    end else begin
                        ram_we = 1'b1;
                        n_wp   = wp_next;
                    end
                end
                n_status = r_status >> 1;
                n_levels = r_levels >> 1;
                if (r_pin == PIN_LAST) begin
                    n_state = ST_DONE;
                end else begin
                    n_pin = r_pin + 1'b1;
                end
            end
            ST_READ: begin
                ram_re  = 1'b1;
                n_rp    = rp_next;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wp    <= '0;
            r_rp    <= '0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
        end
    end

    // Work registers
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_levels <= n_levels;
        r_pin    <= n_pin;
        r_drop   <= n_drop;
        r_hit    <= n_hit;
    end

    // Output valid: set on load, drop after transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_ev_valid <= r_hit;
            r_ev_pin   <= r_hit ? ram_rdata[PIN_W-1:0] : '0;
            r_ev_level <= r_hit ? ram_rdata[PIN_W] : 1'b0;
            r_ev_drop  <= r_drop;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.event_valid    = r_ev_valid;
    assign o_out.event_pin      = r_ev_pin;
    assign o_out.event_level    = r_ev_level;
    assign o_out.events_dropped = r_ev_drop;

    // Checks
    `PIEQ_ASSERT_NEXT(a_push_not_empty, ram_we, r_wp != r_rp, "queue empty after a push")
    `PIEQ_ASSERT_NOW(a_pop_no_drop, o_out.valid && o_out.event_valid, o_out.events_dropped == '0, "popped event carries drops")
    `PIEQ_ASSERT_NEXT(a_hold_result, r_state == ST_DONE && r_out_valid && !o_out.ready, r_state == ST_DONE, "result lost under stall")
    `PIEQ_ASSERT_NOW(a_read_nonempty, ram_re, r_wp != r_rp, "read of empty queue")

endmodule

// File: rtl/core/pieq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read data held between reads.
// ----------------------------------------------------------------------------
module pieq_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [$clog2(DEPTH)-1:0]        i_waddr,
    input  logic [WIDTH-1:0]                i_wdata,
    input  logic                            i_re,
    input  logic [$clog2(DEPTH)-1:0]        i_raddr,
    output logic [WIDTH-1:0]                o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
